// ===== rtl/core/rpsd_pkg.sv =====
// ============================================================================
// rpsd_pkg
// Shared types and constants of the rim protocol sync detector: byte codes,
// rim type codes, detection phases and the decoded item record.
// ============================================================================
package rpsd_pkg;

    // Byte codes seen on the wire.
    localparam logic [7:0] BYTE_52   = 8'h52;
    localparam logic [7:0] BYTE_D2   = 8'hD2;
    localparam logic [7:0] BYTE_E0   = 8'hE0;
    localparam logic [7:0] BYTE_A5   = 8'hA5;
    localparam logic [7:0] BYTE_09   = 8'h09;
    localparam logic [7:0] BYTE_84   = 8'h84;
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    // Format A header, low bit masked off.
    localparam logic [6:0] HDR_A_HI  = 7'h52;

    // Skip lengths.
    localparam logic [5:0] SKIP_52   = 6'd32;
    localparam logic [5:0] SKIP_D2   = 6'd63;
    localparam logic [5:0] SKIP_HIT  = 6'd31;
    localparam logic [5:0] SEARCH_LEN = 6'd35;

    // Rim types.
    localparam logic [1:0] TYPE_NONE = 2'd0;
    localparam logic [1:0] TYPE_A    = 2'd1;
    localparam logic [1:0] TYPE_B    = 2'd2;
    localparam logic [1:0] TYPE_C    = 2'd3;

    // Detection phases.
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SEARCH = 2'd1;
    localparam logic [1:0] PH_SKIP   = 2'd2;

    // Decoupling queue depth.
    localparam int unsigned Q_DEPTH  = 2;

    // One accepted item after decoding.
    typedef struct packed {
        logic       is_header;
        logic       is_52;
        logic       is_d2;
        logic       ends_now;    // 0xE0 or zero as a first byte
        logic       is_a5;
        logic       is_09;
        logic       is_84;
        logic [1:0] byte_type;   // rim type this byte would select
        logic       hdr_a_ok;
        logic       hdr_b_ok;
        logic       hdr_c_ok;
    } t_op;

    // One result item.
    typedef struct packed {
        logic       end_transaction;
        logic       detection_done;
        logic [1:0] rim_type;
    } t_res;

    function automatic logic [1:0] classify(input logic [7:0] b);
        logic [1:0] t;
        t = TYPE_NONE;
        if (b == BYTE_52 || b == BYTE_D2) t = TYPE_A;
        else if (b == BYTE_E0)            t = TYPE_B;
        else if (b == BYTE_A5)            t = TYPE_C;
        return t;
    endfunction

endpackage

// ===== rtl/core/rpsd_front.sv =====
// ============================================================================
// rpsd_front
// Front end: decodes an incoming item into the flags the back end needs.
// ============================================================================
module rpsd_front (
    input  logic             i_req_type,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_next_top_bit,
    input  logic             i_selector_zero,
    output rpsd_pkg::t_op    o_op
);
    import rpsd_pkg::*;

    logic is_52;
    logic is_d2;

    assign is_52 = (i_rx_byte == BYTE_52);
    assign is_d2 = (i_rx_byte == BYTE_D2);

    always_comb begin
        o_op.is_header = i_req_type;
        o_op.is_52     = is_52;
        o_op.is_d2     = is_d2;
        o_op.ends_now  = (i_rx_byte == BYTE_E0) || (i_rx_byte == BYTE_ZERO);
        o_op.is_a5     = (i_rx_byte == BYTE_A5);
        o_op.is_09     = (i_rx_byte == BYTE_09);
        o_op.is_84     = (i_rx_byte == BYTE_84);
        o_op.byte_type = classify(i_rx_byte);
        // A format A header of 0x52 or 0xD2 realigns by one bit to 0xA4 or
        // 0xA5, so it always passes; the next top bit only lands in bit 0,
        // which the check ignores.
        o_op.hdr_a_ok  = is_52 || is_d2 || (i_rx_byte[7:1] == HDR_A_HI)
                         || (i_next_top_bit & 1'b0);
        o_op.hdr_b_ok  = !i_selector_zero || (i_rx_byte == BYTE_E0);
        o_op.hdr_c_ok  = (i_rx_byte == BYTE_A5);
    end

endmodule

// ===== rtl/core/rpsd_queue.sv =====
// ============================================================================
// rpsd_queue
// Short queue of decoded items between the front and back ends.
// ============================================================================
module rpsd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rpsd_pkg::t_op    i_op,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output rpsd_pkg::t_op    o_op
);
    import rpsd_pkg::*;

    localparam int unsigned PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int unsigned CW = $clog2(Q_DEPTH + 1);

    t_op          r_mem [Q_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_op    = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

// ===== rtl/core/rpsd_back.sv =====
// ============================================================================
// rpsd_back
// Back end: runs the detection state machine and the header checks on each
// decoded item and holds the result in an output register.
// ============================================================================
module rpsd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  rpsd_pkg::t_op    i_op,
    output logic             o_q_pop,
    input  logic             i_res_pop,
    output logic             o_res_empty,
    output rpsd_pkg::t_res   o_res
);
    import rpsd_pkg::*;

    logic [1:0] r_held, n_held;
    logic       r_pass, n_pass;
    logic [1:0] r_phase, n_phase;
    logic [5:0] r_cnt, n_cnt;
    logic       r_prior_a5, n_prior_a5;
    logic       r_prior_52, n_prior_52;
    logic [1:0] r_lead, n_lead;
    logic       r_res_valid;
    t_res       r_res, n_res;
    logic       take;
    logic       ended;
    logic [5:0] cnt_dec;

    // A new item may enter whenever the result slot is free or drains now.
    assign take        = !i_q_empty && (!r_res_valid || i_res_pop);
    assign o_q_pop     = take;
    assign o_res_empty = !r_res_valid;
    assign o_res       = r_res;
    assign cnt_dec     = r_cnt - 1'b1;

    always_comb begin
        n_held     = r_held;
        n_pass     = r_pass;
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_prior_a5 = r_prior_a5;
        n_prior_52 = r_prior_52;
        n_lead     = r_lead;
        ended      = 1'b0;
        n_res.detection_done = 1'b0;

        if (i_op.is_header) begin
            unique case (r_held)
                TYPE_A:  if (!i_op.hdr_a_ok) n_held = TYPE_NONE;
                TYPE_B:  if (!i_op.hdr_b_ok) n_held = TYPE_NONE;
                TYPE_C:  if (!i_op.hdr_c_ok) n_held = TYPE_NONE;
                default: n_held = r_held;
            endcase
        end else if (r_held == TYPE_NONE) begin
            unique case (r_phase)
                PH_SEARCH: begin
                    if ((r_prior_a5 && i_op.is_09) || (r_prior_52 && i_op.is_84)) begin
                        n_lead  = r_prior_a5 ? TYPE_C : TYPE_A;
                        n_phase = PH_SKIP;
                        n_cnt   = SKIP_HIT;
                    end else begin
                        n_prior_a5 = i_op.is_a5;
                        n_prior_52 = i_op.is_52;
                        n_cnt      = cnt_dec;
                        ended      = (cnt_dec == '0);
                    end
                end
                PH_SKIP: begin
                    n_cnt = cnt_dec;
                    ended = (cnt_dec == '0);
                end
                default: begin
                    // Awaiting a first byte; the unused code behaves the same.
                    n_lead = i_op.byte_type;
                    if (i_op.is_52) begin
                        n_phase = PH_SKIP;
                        n_cnt   = SKIP_52;
                    end else if (i_op.is_d2) begin
                        n_phase = PH_SKIP;
                        n_cnt   = SKIP_D2;
                    end else if (i_op.ends_now) begin
                        ended = 1'b1;
                    end else begin
                        n_phase    = PH_SEARCH;
                        n_cnt      = SEARCH_LEN;
                        n_prior_a5 = 1'b0;
                        n_prior_52 = 1'b0;
                    end
                end
            endcase

            if (ended) begin
                n_phase = PH_FIRST;
                n_cnt   = '0;
                n_pass  = !r_pass;
                if (r_pass) begin
                    n_held               = n_lead;
                    n_res.detection_done = 1'b1;
                end
            end
        end

        n_res.end_transaction = ended;
        n_res.rim_type        = n_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= TYPE_NONE;
            r_pass      <= 1'b0;
            r_phase     <= PH_FIRST;
            r_cnt       <= '0;
            r_prior_a5  <= 1'b0;
            r_prior_52  <= 1'b0;
            r_lead      <= TYPE_NONE;
            r_res_valid <= 1'b0;
        end else begin
            if (take) begin
                r_held     <= n_held;
                r_pass     <= n_pass;
                r_phase    <= n_phase;
                r_cnt      <= n_cnt;
                r_prior_a5 <= n_prior_a5;
                r_prior_52 <= n_prior_52;
                r_lead     <= n_lead;
            end
            if (take) begin
                r_res_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= n_res;
        end
    end

    // A held type means detection finished cleanly and left its state idle.
    a_held_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held != TYPE_NONE) |-> (r_phase == PH_FIRST && r_cnt == '0 && !r_pass))
        else $error("detection state not idle while a rim type is held");

    // Counting phases never sit on an exhausted counter.
    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIP || r_phase == PH_SEARCH) |-> (r_cnt != '0))
        else $error("skip or search phase with zero byte count");

    // Detection completes only at the end of a transaction.
    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.detection_done) |-> r_res.end_transaction)
        else $error("detection done without end of transaction");

    // Both prior flags cannot describe the same byte.
    a_prior_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_prior_a5 && r_prior_52))
        else $error("prior byte flagged as both 0xA5 and 0x52");

endmodule

// ===== rtl/core/rim_protocol_sync_detect.sv =====
// ============================================================================
// rim_protocol_sync_detect
// Rim protocol sync detector: classifies the attached rim from the bytes it
// clocks out during two detection transactions, then checks frame headers.
// ============================================================================
//
//  Channel   Handshake          Payload
//  -------   ----------------   ------------------------------------------------
//  input     push / full        i_req_type, i_rx_byte, i_next_top_bit,
//                               i_selector_zero
//  result    empty / pop        o_end_transaction, o_detection_done, o_rim_type
//
//  Cycles: one item per clock sustained while pop drains each result. An item
//  is decoded as it is pushed and written into a two-entry queue; the back end
//  then takes it from the queue and loads its result into the output register,
//  so the result reaches the ports through the queue entry and that register.
//  Reset: synchronous, active low; clears the queue, the result valid flag and
//  the detection state (no rim held, first pass, awaiting a first byte).
//  Stalls: while pop is low the result register holds; the back end then
//  stops and the queue absorbs up to two further items before full rises.
//
// The front end only decodes bytes into match flags (the 0x52, 0xD2, 0xE0,
// 0xA5, 0x09 and 0x84 codes, the rim type a byte would select, and the
// pass/fail answer of each header check). The back end owns all detection
// state: the held rim type, the pass index, the phase, the byte counter and
// the lead byte, kept as the rim type it selects, and the prior byte, kept only
// as the flags that the search actually uses.
// ============================================================================
module rim_protocol_sync_detect (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic       i_req_type,
    input  logic [7:0] i_rx_byte,
    input  logic       i_next_top_bit,
    input  logic       i_selector_zero,
    output logic       empty,
    input  logic       pop,
    output logic       o_end_transaction,
    output logic       o_detection_done,
    output logic [1:0] o_rim_type
);
    import rpsd_pkg::*;

    t_op  front_op;
    t_op  q_op;
    logic q_empty;
    logic q_pop;
    t_res res;

    // Decode the incoming item.
    rpsd_front u_front (
        .i_req_type      (i_req_type),
        .i_rx_byte       (i_rx_byte),
        .i_next_top_bit  (i_next_top_bit),
        .i_selector_zero (i_selector_zero),
        .o_op            (front_op)
    );

    // Decouple acceptance from execution.
    rpsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_op    (q_op)
    );

    // Run detection and header checks, one item per clock while results are popped.
    rpsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_op        (q_op),
        .o_q_pop     (q_pop),
        .i_res_pop   (pop),
        .o_res_empty (empty),
        .o_res       (res)
    );

    assign o_end_transaction = res.end_transaction;
    assign o_detection_done  = res.detection_done;
    assign o_rim_type        = res.rim_type;

endmodule
